### sv/adrc_pkg.sv
`default_nettype none
// ============================================================================
// adrc_pkg
// Shared types, constants and lookup tables of the dynamic range compressor.
// ============================================================================
package adrc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int LOG_ENTRIES = 256;
    localparam int EXP_ENTRIES = 256;
    localparam int LOG_IDX_W   = $clog2(LOG_ENTRIES);
    localparam int EXP_IDX_W   = $clog2(EXP_ENTRIES);
    localparam int LEAD_W      = $clog2(SAMPLE_BITS);
    // log2 in Q16 with a signed integer part
    localparam int L2_W        = LEAD_W + 1 + 16;

    localparam int DB_FLOOR    = -24576;
    localparam int GC_MIN      = -131072;
    localparam int GC_MAX      = 131071;
    localparam int GAIN_MIN    = -32768;
    localparam int GAIN_MAX    = 12288;
    localparam int S_MIN       = -(1 << 23);
    localparam int S_MAX       = (1 << 23) - 1;
    localparam logic signed [19:0] DB_PER_LOG2_Q16 = 20'sd394567;
    localparam logic signed [22:0] LOG2_PER_DB_Q24 = 23'sd2786619;

    typedef enum logic [2:0] {
        CFG_THRESHOLD,
        CFG_INV_RATIO,
        CFG_KNEE_WIDTH,
        CFG_KNEE_SCALE,
        CFG_ATTACK,
        CFG_RELEASE,
        CFG_MAKEUP
    } t_cfg_index;

    typedef struct packed {
        logic signed [15:0] threshold_db;
        logic [15:0]        inverse_ratio;
        logic [12:0]        knee_width_db;
        logic [15:0]        knee_scale;
        logic [15:0]        attack_coef;
        logic [15:0]        release_coef;
        logic signed [14:0] makeup_db;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x;
        logic signed [23:0]            gc;
    } t_q_item;

    typedef enum logic [2:0] {
        F_IDLE, F_LOG, F_DB, F_CURVE, F_KNEE, F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE, B_MUL1, B_MUL2, B_GAIN, B_EXP, B_SCALE, B_OUT
    } t_back_state;

    typedef logic [15:0] t_log_tab [LOG_ENTRIES];
    typedef logic [16:0] t_exp_tab [EXP_ENTRIES];

    function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_w;
        v     = v_in;
        res   = 64'd0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w = bit_w >> 2;
        while (bit_w != 64'd0) begin
            if (v >= res + bit_w) begin
                v   = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    // log2(1 + i/L) in Q0.16 by repeated squaring in Q30
    function automatic t_log_tab build_log_tab();
        t_log_tab    tab;
        logic [63:0] y;
        logic [15:0] r;
        for (int i = 0; i < LOG_ENTRIES; i++) begin
            y = (64'd1 << 30) + ((64'(i) << 30) / LOG_ENTRIES);
            r = 16'd0;
            for (int k = 15; k >= 0; k--) begin
                y = (y * y) >> 30;
                if (y >= (64'd1 << 31)) begin
                    y    = y >> 1;
                    r[k] = 1'b1;
                end
            end
            tab[i] = r;
        end
        return tab;
    endfunction

    // 2^(i/E) in Q16 from chained square roots of two
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab    tab;
        logic [63:0] roots [17];
        logic [63:0] t;
        logic [63:0] acc;
        roots[0] = 64'd1 << 31;
        for (int k = 1; k <= 16; k++)
            roots[k] = int_sqrt(roots[k-1] << 30);
        for (int i = 0; i < EXP_ENTRIES; i++) begin
            t   = (64'(i) << 16) / EXP_ENTRIES;
            acc = 64'd1 << 30;
            for (int k = 1; k <= 16; k++)
                if (t[16-k])
                    acc = (acc * roots[k]) >> 30;
            tab[i] = 17'((acc + (64'd1 << 13)) >> 14);
        end
        return tab;
    endfunction

    localparam t_log_tab LOG_TAB = build_log_tab();
    localparam t_exp_tab EXP_TAB = build_exp_tab();

endpackage
`default_nettype wire

### sv/adrc_front.sv
`default_nettype none
// ============================================================================
// adrc_front
// Level detector and static curve: sample to dB, then gain computer value.
// ============================================================================
module adrc_front
    import adrc_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_cfg                          i_cfg,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                               o_push,
    output t_q_item                            o_item,
    input  wire logic                          i_full
);

    t_front_state r_state, n_state;

    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [L2_W-1:0]        r_l2;
    logic                          r_zero;
    logic signed [15:0]            r_xdb;
    logic signed [17:0]            r_d;
    logic signed [19:0]            r_above;
    logic [14:0]                   r_v;
    logic [29:0]                   r_vv;

    logic [SAMPLE_BITS-1:0]               mag;
    logic [LEAD_W-1:0]                    lead;
    logic [SAMPLE_BITS-1:0]               frac;
    logic [SAMPLE_BITS+LOG_IDX_W-1:0]     idx_wide;
    logic [LOG_IDX_W-1:0]                 idx;
    logic signed [LEAD_W:0]               e_rel;
    logic signed [L2_W+19:0]              db_prod;
    logic signed [L2_W-5:0]               db_sh;
    logic signed [17:0]                   d;
    logic signed [34:0]                   d_prod;
    logic signed [19:0]                   above;
    logic signed [19:0]                   two_d;
    logic signed [19:0]                   w_ext;
    logic signed [19:0]                   v_full;
    logic signed [19:0]                   two_rd;
    logic [45:0]                          k_prod;
    logic signed [20:0]                   gc_raw;
    logic signed [17:0]                   gc_sat;

    always_comb begin
        mag  = r_x[SAMPLE_BITS-1] ? (~r_x + 1'b1) : r_x;
        lead = '0;
        for (int i = 0; i < SAMPLE_BITS; i++)
            if (mag[i])
                lead = LEAD_W'(i);
        frac     = mag & ~(SAMPLE_BITS'(1) << lead);
        idx_wide = ({LOG_IDX_W'(0), frac} << LOG_IDX_W) >> lead;
        idx      = idx_wide[LOG_IDX_W-1:0];
        e_rel    = $signed({1'b0, lead}) - (LEAD_W+1)'(SAMPLE_BITS - 1);

        db_prod = r_l2 * DB_PER_LOG2_Q16;
        db_sh   = (L2_W-4)'(db_prod >>> 24);

        d      = 18'(r_xdb) - 18'(i_cfg.threshold_db);
        d_prod = d * $signed({1'b0, i_cfg.inverse_ratio});
        above  = 20'(d_prod >>> 16) - 20'(d);
        two_d  = 20'(d) <<< 1;
        w_ext  = $signed({7'd0, i_cfg.knee_width_db});
        v_full = two_d + w_ext;

        two_rd = 20'(r_d) <<< 1;
        k_prod = r_vv * {30'd0, i_cfg.knee_scale};
        if (i_cfg.knee_width_db == '0) begin
            gc_raw = (r_d <= 0) ? 21'sd0 : 21'(r_above);
        end else if (two_rd < -w_ext) begin
            gc_raw = 21'sd0;
        end else if (two_rd > w_ext) begin
            gc_raw = 21'(r_above);
        end else begin
            gc_raw = -$signed({1'b0, k_prod[45:26]});
        end
        if (gc_raw < GC_MIN)
            gc_sat = 18'(GC_MIN);
        else if (gc_raw > GC_MAX)
            gc_sat = 18'(GC_MAX);
        else
            gc_sat = 18'(gc_raw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= F_IDLE;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_push  = 1'b0;
        o_item  = '{x: r_x, gc: {gc_sat, 6'd0}};
        unique case (r_state)
            F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid)
                    n_state = F_LOG;
            end
            F_LOG:   n_state = F_DB;
            F_DB:    n_state = F_CURVE;
            F_CURVE: n_state = F_KNEE;
            F_KNEE:  n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_valid)
            r_x <= i_sample_in;
        if (r_state == F_LOG) begin
            r_l2   <= $signed({e_rel, LOG_TAB[idx]});
            r_zero <= (mag == '0);
        end
        if (r_state == F_DB) begin
            if (r_zero || db_sh < DB_FLOOR)
                r_xdb <= 16'(DB_FLOOR);
            else if (db_sh > 0)
                r_xdb <= 16'sd0;
            else
                r_xdb <= 16'(db_sh);
        end
        if (r_state == F_CURVE) begin
            r_d     <= d;
            r_above <= above;
            r_v     <= v_full[14:0];
        end
        if (r_state == F_KNEE)
            r_vv <= {15'd0, r_v} * {15'd0, r_v};
    end

endmodule
`default_nettype wire

### sv/adrc_queue.sv
`default_nettype none
// ============================================================================
// adrc_queue
// Two-entry queue of classified items between the front and back ends.
// ============================================================================
module adrc_queue
    import adrc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_q_item i_item,
    output logic         o_full,
    input  wire logic    i_pop,
    output t_q_item      o_item,
    output logic         o_empty
);

    t_q_item    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push)
                r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)
                r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_item;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from empty queue");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3) else $error("queue count out of range");
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) == (r_wr_ptr != r_rd_ptr)) else $error("pointer mismatch");

endmodule
`default_nettype wire

### sv/adrc_back.sv
`default_nettype none
// ============================================================================
// adrc_back
// Gain smoothing, makeup, dB to linear conversion and sample scaling.
// ============================================================================
module adrc_back
    import adrc_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_cfg                          i_cfg,
    input  wire logic                          i_empty,
    input  wire t_q_item                       i_item,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out,
    output logic signed [15:0]                 o_applied_gain_db
);

    t_back_state r_state, n_state;

    logic signed [23:0]               r_s;
    logic signed [SAMPLE_BITS-1:0]    r_x;
    logic signed [23:0]               r_gc;
    logic [15:0]                      r_a;
    logic signed [40:0]               r_acc;
    logic signed [15:0]               r_g;
    logic signed [22:0]               r_p;
    logic signed [SAMPLE_BITS+17:0]   r_prod;
    logic [5:0]                       r_sh;
    logic                             r_out_valid;
    logic signed [SAMPLE_BITS-1:0]    r_y;
    logic signed [15:0]               r_out_g;

    logic signed [17:0]               one_m_a;
    logic signed [41:0]               sum;
    logic signed [25:0]               s_new;
    logic signed [18:0]               g_sum;
    logic signed [38:0]               p_prod;
    logic signed [6:0]                n_int;
    logic [31:0]                      j_prod;
    logic [EXP_IDX_W-1:0]             j;
    logic signed [7:0]                sh_raw;
    logic signed [SAMPLE_BITS+17:0]   y_full;
    logic                             out_free;

    always_comb begin
        one_m_a = 18'sd65536 - $signed({2'b0, r_a});
        sum     = 42'(r_acc) + one_m_a * r_gc;
        s_new   = 26'(sum >>> 16);
        g_sum   = 19'(r_s >>> 6) + 19'(i_cfg.makeup_db);
        p_prod  = r_g * LOG2_PER_DB_Q24;
        n_int   = r_p[22:16];
        j_prod  = {16'd0, r_p[15:0]} * 32'(EXP_ENTRIES);
        j       = j_prod[16 +: EXP_IDX_W];
        sh_raw  = 8'sd16 - 8'(n_int);
        y_full  = r_prod >>> r_sh;
        out_free = !r_out_valid || i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= B_IDLE;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = B_MUL1;
                end
            end
            B_MUL1:  n_state = B_MUL2;
            B_MUL2:  n_state = B_GAIN;
            B_GAIN:  n_state = B_EXP;
            B_EXP:   n_state = B_SCALE;
            B_SCALE: n_state = B_OUT;
            B_OUT: begin
                if (out_free)
                    n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // smoothed gain is state: cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == B_MUL2) begin
                if (s_new < S_MIN)
                    r_s <= 24'(S_MIN);
                else if (s_new > S_MAX)
                    r_s <= 24'(S_MAX);
                else
                    r_s <= 24'(s_new);
            end
            if (r_state == B_OUT && out_free)
                r_out_valid <= 1'b1;
            else if (i_ready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_x  <= i_item.x;
            r_gc <= i_item.gc;
            r_a  <= (i_item.gc <= r_s) ? i_cfg.attack_coef : i_cfg.release_coef;
        end
        if (r_state == B_MUL1)
            r_acc <= $signed({1'b0, r_a}) * r_s;
        if (r_state == B_GAIN) begin
            if (g_sum < GAIN_MIN)
                r_g <= 16'(GAIN_MIN);
            else if (g_sum > GAIN_MAX)
                r_g <= 16'(GAIN_MAX);
            else
                r_g <= 16'(g_sum);
        end
        if (r_state == B_EXP)
            r_p <= 23'(p_prod >>> 16);
        if (r_state == B_SCALE) begin
            r_prod <= r_x * $signed({1'b0, EXP_TAB[j]});
            if (sh_raw < 0)
                r_sh <= 6'd0;
            else if (sh_raw > 62)
                r_sh <= 6'd62;
            else
                r_sh <= 6'(sh_raw);
        end
        if (r_state == B_OUT && out_free) begin
            if (y_full > (2**(SAMPLE_BITS-1)) - 1)
                r_y <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            else if (y_full < -(2**(SAMPLE_BITS-1)))
                r_y <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            else
                r_y <= SAMPLE_BITS'(y_full);
            r_out_g <= r_g;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_sample_out      = r_y;
    assign o_applied_gain_db = r_out_g;

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_EXP) |-> (r_g >= GAIN_MIN && r_g <= GAIN_MAX))
        else $error("applied gain outside range");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == B_IDLE)) else $error("pop while busy");

endmodule
`default_nettype wire

### sv/audio_dynamic_range_compressor.sv
`default_nettype none
// ============================================================================
// audio_dynamic_range_compressor
// Feedforward log-domain compressor with hard or soft knee.
// ============================================================================
// Input channel i_valid/o_ready carries one signed sample per item; output
// channel o_valid/i_ready returns the scaled, saturated sample and the gain
// in dB (Q8.8) applied to it. Registers are written through i_cfg_wr_en,
// i_cfg_index and i_cfg_wdata; the user must write them only while the
// block is idle, which the block itself does not enforce; index 7 is
// ignored. The front end (level in dB, static curve) takes one item at a
// time and hands its result to a two-entry queue; the back end (smoothing,
// makeup, exp table, multiply) also takes one item at a time, so the front
// end can work on the next sample while the back end finishes the last.
// Reset (synchronous, active low) restores the register defaults, clears
// the smoothed gain and empties the queue. When the receiver stalls the
// result stays in the output register, the back end holds its next result,
// and the front end fills the queue and then drops o_ready.
module audio_dynamic_range_compressor
    import adrc_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [2:0]                    i_cfg_index,
    input  wire logic [15:0]                   i_cfg_wdata,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out,
    output logic signed [15:0]                 o_applied_gain_db
);

    t_cfg    r_cfg;
    logic    push, pop, full, empty;
    t_q_item q_in, q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_db  <= -16'sd5120;
            r_cfg.inverse_ratio <= 16'd32768;
            r_cfg.knee_width_db <= 13'd0;
            r_cfg.knee_scale    <= 16'd0;
            r_cfg.attack_coef   <= 16'd65405;
            r_cfg.release_coef  <= 16'd65522;
            r_cfg.makeup_db     <= 15'sd2560;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD:  r_cfg.threshold_db  <= i_cfg_wdata;
                CFG_INV_RATIO:  r_cfg.inverse_ratio <= i_cfg_wdata;
                CFG_KNEE_WIDTH: r_cfg.knee_width_db <= i_cfg_wdata[12:0];
                CFG_KNEE_SCALE: r_cfg.knee_scale    <= i_cfg_wdata;
                CFG_ATTACK:     r_cfg.attack_coef   <= i_cfg_wdata;
                CFG_RELEASE:    r_cfg.release_coef  <= i_cfg_wdata;
                CFG_MAKEUP:     r_cfg.makeup_db     <= i_cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    adrc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample_in (i_sample_in),
        .o_push      (push),
        .o_item      (q_in),
        .i_full      (full)
    );

    adrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (q_out),
        .o_empty (empty)
    );

    adrc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_empty           (empty),
        .i_item            (q_out),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_sample_out      (o_sample_out),
        .o_applied_gain_db (o_applied_gain_db)
    );

endmodule
`default_nettype wire

### bench/adrc_gain_checker.sv
`default_nettype none
// ============================================================================
// adrc_gain_checker
// Watches the register port and both channels of the compressor. It predicts
// every result with its own fixed-point model and compares each output item
// with the oldest prediction.
// ============================================================================
module adrc_gain_checker
    import adrc_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [2:0]                    i_cfg_index,
    input  wire logic [15:0]                   i_cfg_wdata,
    input  wire logic                          i_valid,
    input  wire logic                          i_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_out,
    input  wire logic signed [15:0]            i_applied_gain_db,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic signed [15:0]            gain;
    } t_scaled_item;

    t_scaled_item expected_out_q[$];

    longint unsigned log2_tab [LOG_ENTRIES];
    longint unsigned pow2_tab [EXP_ENTRIES];

    t_cfg   regs;
    longint gain_state;

    function automatic longint unsigned sqrt_floor(input longint unsigned v_in);
        longint unsigned v, res, b;
        v   = v_in;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    initial begin
        longint unsigned y, t, acc;
        longint unsigned roots [17];
        for (int i = 0; i < LOG_ENTRIES; i++) begin
            y = (64'd1 << 30) + ((64'(i) << 30) / LOG_ENTRIES);
            log2_tab[i] = 0;
            for (int k = 15; k >= 0; k--) begin
                y = (y * y) >> 30;
                if (y >= (64'd1 << 31)) begin
                    y = y >> 1;
                    log2_tab[i] = log2_tab[i] | (64'd1 << k);
                end
            end
        end
        roots[0] = 64'd1 << 31;
        for (int k = 1; k <= 16; k++)
            roots[k] = sqrt_floor(roots[k-1] << 30);
        for (int i = 0; i < EXP_ENTRIES; i++) begin
            t   = (64'(i) << 16) / EXP_ENTRIES;
            acc = 64'd1 << 30;
            for (int k = 1; k <= 16; k++)
                if (t[16-k])
                    acc = (acc * roots[k]) >> 30;
            pow2_tab[i] = (acc + (64'd1 << 13)) >> 14;
        end
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // advances the smoothed gain and returns the scaled sample and its gain
    function automatic t_scaled_item compress_sample(input logic signed [SAMPLE_BITS-1:0] xs);
        longint x, mag, e, idx, lvl, d, w, above, gc, a, g, p, n, f, j, sh, v;
        t_scaled_item r;
        x   = xs;
        mag = x < 0 ? -x : x;
        if (mag == 0) begin
            lvl = DB_FLOOR;
        end else begin
            e = 0;
            while ((mag >> (e + 1)) != 0)
                e++;
            idx = ((mag - (64'sd1 << e)) * LOG_ENTRIES) >>> e;
            if (idx >= LOG_ENTRIES)
                idx = LOG_ENTRIES - 1;
            lvl = (e - (SAMPLE_BITS - 1)) * 65536 + longint'(log2_tab[idx]);
            lvl = clip((lvl * 394567) >>> 24, DB_FLOOR, 0);
        end

        d     = lvl - longint'(regs.threshold_db);
        w     = longint'(regs.knee_width_db);
        above = ((d * longint'(regs.inverse_ratio)) >>> 16) - d;
        if (w == 0) begin
            gc = d <= 0 ? 0 : above;
        end else if (2 * d < -w) begin
            gc = 0;
        end else if (2 * d > w) begin
            gc = above;
        end else begin
            v  = 2 * d + w;
            gc = -((v * v * longint'(regs.knee_scale)) >>> 26);
        end
        gc = clip(gc, GC_MIN, GC_MAX) * 64;

        a = gc <= gain_state ? longint'(regs.attack_coef) : longint'(regs.release_coef);
        gain_state = (a * gain_state + (65536 - a) * gc) >>> 16;
        gain_state = clip(gain_state, S_MIN, S_MAX);

        g = clip((gain_state >>> 6) + longint'(regs.makeup_db), GAIN_MIN, GAIN_MAX);
        p = (g * 2786619) >>> 16;
        n = p >>> 16;
        f = p - n * 65536;
        j = (f * EXP_ENTRIES) >>> 16;
        if (j >= EXP_ENTRIES)
            j = EXP_ENTRIES - 1;
        sh = clip(16 - n, 0, 62);
        v  = (x * longint'(pow2_tab[j])) >>> sh;
        v  = clip(v, -(64'sd1 << (SAMPLE_BITS - 1)), (64'sd1 << (SAMPLE_BITS - 1)) - 1);
        r.sample = v[SAMPLE_BITS-1:0];
        r.gain   = g[15:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    assign o_pending = expected_out_q.size();

    always @(posedge i_clk) begin
        t_scaled_item got, want;
        if (!i_rst_n) begin
            regs.threshold_db  = -16'sd5120;
            regs.inverse_ratio = 16'd32768;
            regs.knee_width_db = 13'd0;
            regs.knee_scale    = 16'd0;
            regs.attack_coef   = 16'd65405;
            regs.release_coef  = 16'd65522;
            regs.makeup_db     = 15'sd2560;
            gain_state         = 0;
            expected_out_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_THRESHOLD:  regs.threshold_db  = i_cfg_wdata;
                    CFG_INV_RATIO:  regs.inverse_ratio = i_cfg_wdata;
                    CFG_KNEE_WIDTH: regs.knee_width_db = i_cfg_wdata[12:0];
                    CFG_KNEE_SCALE: regs.knee_scale    = i_cfg_wdata;
                    CFG_ATTACK:     regs.attack_coef   = i_cfg_wdata;
                    CFG_RELEASE:    regs.release_coef  = i_cfg_wdata;
                    CFG_MAKEUP:     regs.makeup_db     = i_cfg_wdata[14:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_ready) begin
                got.sample = i_sample_out;
                got.gain   = i_applied_gain_db;
                if (expected_out_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected item sample=%0d gain=%0d",
                                              got.sample, got.gain));
                end else begin
                    want = expected_out_q.pop_front();
                    if (got.sample !== want.sample)
                        report_mismatch($sformatf("sample_out %0d, expected %0d",
                                                  got.sample, want.sample));
                    if (got.gain !== want.gain)
                        report_mismatch($sformatf("applied_gain_db %0d, expected %0d",
                                                  got.gain, want.gain));
                end
            end
            if (i_valid && i_in_ready)
                expected_out_q.push_back(compress_sample(i_sample_in));
        end
    end

endmodule
`default_nettype wire

### bench/tb_audio_dynamic_range_compressor.sv
`default_nettype none
// ============================================================================
// tb_audio_dynamic_range_compressor
// Drives directed and random samples through the compressor under several
// register settings and idle patterns; the checker predicts and compares.
// ============================================================================
module tb_audio_dynamic_range_compressor;
    import adrc_pkg::*;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_wr_en = 1'b0;
    logic [2:0]                    i_cfg_index = '0;
    logic [15:0]                   i_cfg_wdata = '0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic signed [SAMPLE_BITS-1:0] i_sample_in = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_sample_out;
    logic signed [15:0]            o_applied_gain_db;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;

    always #1 i_clk = ~i_clk;

    audio_dynamic_range_compressor dut (.*);

    adrc_gain_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_index, .i_cfg_wdata,
        .i_valid, .i_in_ready(o_ready), .i_sample_in,
        .i_out_valid(o_valid), .i_ready, .i_sample_out(o_sample_out),
        .i_applied_gain_db(o_applied_gain_db),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        static int hold_left = 0;
        static int holds_seen = 0;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (hold_requests != holds_seen) begin
                holds_seen = hold_requests;
                hold_left  = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
        i_valid     <= 1'b1;
        i_sample_in <= s;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [15:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic drain_outputs();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic load_setting(input int phase);
        logic [15:0] thr, inv, kw, ks, atk, rel, mk;
        thr = 16'(-$urandom_range(0, 32768));
        inv = 16'($urandom);
        kw  = $urandom_range(3) == 0 ? 16'd0 : 16'($urandom_range(0, 6144));
        ks  = 16'($urandom);
        atk = 16'($urandom_range(60000, 65535));
        rel = 16'($urandom_range(50000, 65535));
        mk  = 16'($urandom_range(0, 24576) - 12288);
        case (phase)
            1: begin
                thr = 16'd0; inv = 16'd0; kw = 16'd8191; ks = 16'hFFFF;
                atk = 16'd0; rel = 16'hFFFF; mk = 16'd12288;
            end
            2: begin
                thr = 16'h8000; inv = 16'hFFFF; kw = 16'd0; ks = 16'd0;
                atk = 16'hFFFF; rel = 16'd0; mk = 16'(-12288);
            end
            3: begin
                kw = 16'd6144; mk = 16'h4000;  // most negative 15-bit makeup
            end
            default: ;
        endcase
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_INV_RATIO, inv);
        write_reg(CFG_KNEE_WIDTH, kw);
        write_reg(CFG_KNEE_SCALE, ks);
        write_reg(CFG_ATTACK, atk);
        write_reg(CFG_RELEASE, rel);
        write_reg(CFG_MAKEUP, mk);
        write_reg(t_cfg_index'(3'd7), 16'hFFFF);  // unused index, ignored
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        int sel;
        logic [15:0] v;
        sel = $urandom_range(99);
        v   = 16'($urandom);
        if (sel < 5)
            return '0;
        if (sel < 45)
            return $signed(v) >>> $urandom_range(0, 15);
        return v;
    endfunction

    initial begin
        static logic signed [SAMPLE_BITS-1:0] directed [] = '{
            16'sd0, 16'sd32767, 16'sh8000, 16'sd1, -16'sd1, 16'sd2, -16'sd2,
            16'sd16384, -16'sd16384, 16'sd16383, 16'sd255, 16'sd256, -16'sd257,
            16'sd1000, -16'sd5000, 16'sd32767, 16'sd32767, 16'sd0, 16'sd0,
            16'sd0, 16'sh5555, -16'sh5556, 16'sd8191, 16'sd12};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 38;
        recv_idle_pct = 65;
        foreach (directed[k])
            send_sample(directed[k]);
        drain_outputs();

        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 2) begin
                send_idle_pct = 65;
                recv_idle_pct = 38;
            end else if (phase == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_setting(phase);
            if (phase == 4)
                hold_requests++;
            for (int k = 0; k < 165; k++)
                send_sample(random_sample());
            drain_outputs();
        end

        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
